FILE: sv/assert_macros.svh
// assertion macros shared by the blend block
// no dependencies; included by the top level only
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define SABL_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define SABL_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SABL_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SABL_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: sv/sabl_pkg.sv
// types, register indexes and channel arithmetic for the sprite blend block
// no dependencies; imported by every module of the block
package sabl_pkg;

    localparam int PIX_W     = 32;
    localparam int CH_W      = 8;
    localparam int NUM_CH    = 4;
    localparam int NUM_TAPS  = 4;
    localparam int IN_W      = 5 * PIX_W;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAC_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAC_Y = 2'd1;

    typedef logic [NUM_TAPS-1:0][CH_W-1:0] weights_t;

    // one resampled sprite pixel waiting to be blended
    typedef struct packed {
        logic [PIX_W-1:0] sum;
        logic [PIX_W-1:0] dest;
        logic             blend;
    } q_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    // (a*b)>>8 on two 8-bit values
    function automatic logic [CH_W-1:0] mul_shr8(input logic [CH_W-1:0] a,
                                                 input logic [CH_W-1:0] b);
        logic [2*CH_W-1:0] p;
        p = {{CH_W{1'b0}}, a} * {{CH_W{1'b0}}, b};
        return p[2*CH_W-1:CH_W];
    endfunction

    // every channel scaled by one weight
    function automatic logic [PIX_W-1:0] scale_argb(input logic [PIX_W-1:0] c,
                                                    input logic [CH_W-1:0]  w);
        logic [PIX_W-1:0] r;
        r = '0;
        for (int i = 0; i < NUM_CH; i++)
        begin
            r[CH_W*i +: CH_W] = mul_shr8(c[CH_W*i +: CH_W], w);
        end
        return r;
    endfunction

    // per channel add, clamped at full scale
    function automatic logic [PIX_W-1:0] add_argb(input logic [PIX_W-1:0] a,
                                                  input logic [PIX_W-1:0] b);
        logic [PIX_W-1:0] r;
        logic [CH_W:0]    s;
        r = '0;
        for (int i = 0; i < NUM_CH; i++)
        begin
            s = {1'b0, a[CH_W*i +: CH_W]} + {1'b0, b[CH_W*i +: CH_W]};
            r[CH_W*i +: CH_W] = s[CH_W] ? {CH_W{1'b1}} : s[CH_W-1:0];
        end
        return r;
    endfunction

endpackage

FILE: sv/sabl_queue.sv
// short queue of resampled pixels between front and back
// depends on sabl_pkg
module sabl_queue
    import sabl_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  q_entry_t in_entry,
    output logic     out_valid,
    input  logic     out_ready,
    output q_entry_t out_entry,
    output q_stat_t  stat
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    q_entry_t             mem_reg [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 push, pop;

    assign in_ready   = (count_reg != CNT_W'(DEPTH));
    assign out_valid  = (count_reg != '0);
    assign out_entry  = mem_reg[rd_ptr_reg];
    assign stat.full  = !in_ready;
    assign stat.empty = !out_valid;

    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_reg + 1'b1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_reg + 1'b1);
        end
        if (push && !pop)
        begin
            count_next = CNT_W'(count_reg + 1'b1);
        end
        else if (pop && !push)
        begin
            count_next = CNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_entry;
        end
    end

endmodule

FILE: sv/sabl_front.sv
// front end: fraction registers, weight stage and resample stage
// depends on sabl_pkg; feeds sabl_queue
module sabl_front
    import sabl_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CH_W-1:0]      cfg_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [IN_W-1:0]      s_tdata,
    output logic                 q_valid,
    input  logic                 q_ready,
    output q_entry_t             q_entry
);

    logic [CH_W-1:0] frac_x_reg, frac_x_next;
    logic [CH_W-1:0] frac_y_reg, frac_y_next;

    logic            a_valid_reg, a_valid_next;
    logic [IN_W-1:0] a_pix_reg, a_pix_next;
    weights_t        a_wgt_reg, a_wgt_next;
    logic            a_ready;

    logic            b_valid_reg, b_valid_next;
    q_entry_t        b_entry_reg, b_entry_next;
    logic            b_ready;

    logic [PIX_W-1:0] sum;

    // configuration writes
    always_comb
    begin
        frac_x_next = frac_x_reg;
        frac_y_next = frac_y_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_FRAC_X: frac_x_next = cfg_data;
                CFG_FRAC_Y: frac_y_next = cfg_data;
                default:    ;
            endcase
        end
    end

    assign b_ready  = !b_valid_reg || q_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign s_tready = a_ready;

    // weight stage: ~f is 255-f on eight bits
    always_comb
    begin
        a_valid_next = a_ready ? s_tvalid : a_valid_reg;
        a_pix_next   = a_pix_reg;
        a_wgt_next   = a_wgt_reg;
        if (a_ready && s_tvalid)
        begin
            a_pix_next    = s_tdata;
            a_wgt_next[0] = mul_shr8(frac_x_reg, frac_y_reg);
            a_wgt_next[1] = mul_shr8(~frac_x_reg, frac_y_reg);
            a_wgt_next[2] = mul_shr8(frac_x_reg, ~frac_y_reg);
            a_wgt_next[3] = mul_shr8(~frac_x_reg, ~frac_y_reg);
        end
    end

    // resample stage
    always_comb
    begin
        sum = add_argb(
                  add_argb(
                      add_argb(scale_argb(a_pix_reg[0*PIX_W +: PIX_W], a_wgt_reg[0]),
                               scale_argb(a_pix_reg[1*PIX_W +: PIX_W], a_wgt_reg[1])),
                      scale_argb(a_pix_reg[2*PIX_W +: PIX_W], a_wgt_reg[2])),
                  scale_argb(a_pix_reg[3*PIX_W +: PIX_W], a_wgt_reg[3]));
        b_valid_next = b_ready ? a_valid_reg : b_valid_reg;
        b_entry_next = b_entry_reg;
        if (b_ready && a_valid_reg)
        begin
            b_entry_next.sum   = sum;
            b_entry_next.dest  = a_pix_reg[4*PIX_W +: PIX_W];
            b_entry_next.blend = (sum[PIX_W-1 -: CH_W] != '0);
        end
    end

    assign q_valid = b_valid_reg;
    assign q_entry = b_entry_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frac_x_reg  <= '0;
            frac_y_reg  <= '0;
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            frac_x_reg  <= frac_x_next;
            frac_y_reg  <= frac_y_next;
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_pix_reg   <= a_pix_next;
        a_wgt_reg   <= a_wgt_next;
        b_entry_reg <= b_entry_next;
    end

endmodule

FILE: sv/sabl_back.sv
// back end: alpha blend over the destination and output register
// depends on sabl_pkg; drains sabl_queue
module sabl_back
    import sabl_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    output logic             q_ready,
    input  q_entry_t         q_entry,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [PIX_W-1:0] m_tdata,
    output logic [0:0]       m_tuser
);

    logic             out_valid_reg, out_valid_next;
    logic [PIX_W-1:0] out_pixel_reg, out_pixel_next;
    logic             changed_reg, changed_next;
    logic [CH_W-1:0]  alpha;
    logic [PIX_W-1:0] blended;

    assign q_ready = !out_valid_reg || m_tready;

    always_comb
    begin
        alpha   = q_entry.sum[PIX_W-1 -: CH_W];
        blended = add_argb(scale_argb(q_entry.sum, alpha), scale_argb(q_entry.dest, ~alpha));
        out_valid_next = q_ready ? q_valid : out_valid_reg;
        out_pixel_next = out_pixel_reg;
        changed_next   = changed_reg;
        if (q_ready && q_valid)
        begin
            // zero alpha passes the destination through
            out_pixel_next = q_entry.blend ? blended : q_entry.dest;
            changed_next   = q_entry.blend;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_pixel_reg;
    assign m_tuser[0] = changed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_pixel_reg <= out_pixel_next;
        changed_reg   <= changed_next;
    end

endmodule

FILE: sv/subpixel_sprite_alpha_blend_top.sv
// top level of the sub-pixel sprite resample and alpha blend block
// depends on sabl_pkg, sabl_front, sabl_queue, sabl_back and assert_macros.svh

// Resamples one sprite pixel from four ARGB8888 neighbors with the sub-pixel
// fractions frac_x (index 0) and frac_y (index 1), then blends it over the
// destination pixel by its own alpha; zero alpha returns the destination and
// clears changed. Fully pipelined: one pixel per clock is taken and delivered
// in steady state while m_tready stays high. An input transaction passes the
// weight multiply, the channel multiply and sum, the queue and the blend multiply
// into the output register. The queue of QUEUE_DEPTH entries (at least 2) lets the
// front keep accepting while the output side is stalled. No clearing pass
// follows reset. Write configuration only while no pixel is in flight.
`include "assert_macros.svh"

module subpixel_sprite_alpha_blend_top
    import sabl_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CH_W-1:0]      cfg_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // top_left, top_right, bottom_left, bottom_right, dest_pixel
    input  logic [IN_W-1:0]      s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // out_pixel
    output logic [PIX_W-1:0]     m_tdata,
    // changed
    output logic [0:0]           m_tuser
);

    logic     f_valid, f_ready;
    q_entry_t f_entry;
    logic     q_valid, q_ready;
    q_entry_t q_entry;
    q_stat_t  q_stat;

    assign cfg_ready = 1'b1;

    sabl_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .q_valid   (f_valid),
        .q_ready   (f_ready),
        .q_entry   (f_entry)
    );

    sabl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_entry  (f_entry),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_entry (q_entry),
        .stat      (q_stat)
    );

    sabl_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_entry  (q_entry),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // a full queue always has something to offer the back end
    `SABL_ASSERT_IMP(a_full_nonempty, clk, rst_n, q_stat.full, q_valid && !q_stat.empty)
    // blend flag matches the resampled alpha
    `SABL_ASSERT_IMP(a_flag_alpha, clk, rst_n, q_valid,
                     q_entry.blend == (q_entry.sum[PIX_W-1 -: CH_W] != '0))
    // zero alpha transaction comes out as the destination, unchanged
    `SABL_ASSERT_NXT(a_pass_dest, clk, rst_n, q_valid && q_ready && !q_entry.blend,
                     m_tvalid && !m_tuser[0] && m_tdata == $past(q_entry.dest))

endmodule

FILE: verif/subpixel_sprite_alpha_blend_top_tb.sv
// self-checking testbench for the sub-pixel sprite resample and alpha blend block
// depends on sabl_pkg and the subpixel_sprite_alpha_blend_top rtl
`timescale 1ns / 100ps

module subpixel_sprite_alpha_blend_top_tb;
    import sabl_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RAND_PHASES = 10;
    localparam int PHASE_ITEMS = 103;

    // indexes past the two fraction registers, writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    typedef enum logic [1:0] {
        IDLE_SEND_LIGHT,
        IDLE_SEND_HEAVY,
        IDLE_NONE
    } idle_mode_t;

    typedef struct {
        logic [PIX_W-1:0] top_left;
        logic [PIX_W-1:0] top_right;
        logic [PIX_W-1:0] bottom_left;
        logic [PIX_W-1:0] bottom_right;
        logic [PIX_W-1:0] dest_pixel;
    } sprite_quad_t;

    typedef struct {
        logic [PIX_W-1:0] out_pixel;
        logic             changed;
    } blended_px_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CH_W-1:0]      cfg_data = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [IN_W-1:0]      s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [PIX_W-1:0]     m_tdata;
    logic [0:0]           m_tuser;

    sprite_quad_t  quads_to_send[$];
    blended_px_t   predicted_px[$];
    sprite_quad_t  quad_on_bus;
    idle_mode_t    idle_mode = IDLE_SEND_LIGHT;
    logic [CH_W-1:0] frac_x_sh;
    logic [CH_W-1:0] frac_y_sh;
    int            fail_cnt = 0;
    int            checked_cnt = 0;
    int            passthru_cnt = 0;
    int            setting_cnt = 0;
    int            cycle_cnt = 0;

    subpixel_sprite_alpha_blend_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // resample four taps with the current fractions, then blend over dest
    function automatic blended_px_t blend_predict(input sprite_quad_t q,
                                                  input logic [CH_W-1:0] fx_in,
                                                  input logic [CH_W-1:0] fy_in);
        int fx;
        int fy;
        int wt[4];
        logic [PIX_W-1:0] taps[4];
        int acc[4];
        int alpha;
        int dch;
        int mixed;
        blended_px_t res;
        fx = fx_in;
        fy = fy_in;
        wt[0] = (fx * fy) >> 8;
        wt[1] = ((255 - fx) * fy) >> 8;
        wt[2] = (fx * (255 - fy)) >> 8;
        wt[3] = ((255 - fx) * (255 - fy)) >> 8;
        taps[0] = q.top_left;
        taps[1] = q.top_right;
        taps[2] = q.bottom_left;
        taps[3] = q.bottom_right;
        for (int ch = 0; ch < 4; ch++)
        begin
            acc[ch] = 0;
            for (int t = 0; t < 4; t++)
            begin
                acc[ch] += (int'(taps[t][8*ch +: 8]) * wt[t]) >> 8;
            end
        end
        alpha = acc[3];
        res.out_pixel = q.dest_pixel;
        res.changed = 1'b0;
        if (alpha != 0)
        begin
            res.changed = 1'b1;
            for (int ch = 0; ch < 4; ch++)
            begin
                dch = q.dest_pixel[8*ch +: 8];
                mixed = ((acc[ch] * alpha) >> 8) + ((dch * (255 - alpha)) >> 8);
                res.out_pixel[8*ch +: 8] = mixed[7:0];
            end
        end
        return res;
    endfunction

    function automatic bit roll_idle(input int pct);
        return $urandom_range(99) < pct;
    endfunction

    // shadow of the fraction registers, follows accepted config transactions
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frac_x_sh <= '0;
            frac_y_sh <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_FRAC_X)
                frac_x_sh <= cfg_data;
            else if (cfg_index == CFG_FRAC_Y)
                frac_y_sh <= cfg_data;
        end
    end

    // input driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                predicted_px.push_back(blend_predict(quad_on_bus, frac_x_sh, frac_y_sh));
            if (!s_tvalid || s_tready)
            begin
                if (quads_to_send.size() > 0 &&
                    !(idle_mode == IDLE_SEND_LIGHT && roll_idle(32)) &&
                    !(idle_mode == IDLE_SEND_HEAVY && roll_idle(87)))
                begin
                    quad_on_bus = quads_to_send.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {quad_on_bus.dest_pixel, quad_on_bus.bottom_right,
                                 quad_on_bus.bottom_left, quad_on_bus.top_right,
                                 quad_on_bus.top_left};
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // output monitor and checker
    always @(posedge clk or negedge rst_n)
    begin
        blended_px_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (predicted_px.size() == 0)
                begin
                    $error("unexpected transaction: out_pixel %h changed %0d", m_tdata, m_tuser);
                    fail_cnt++;
                end
                else
                begin
                    want = predicted_px.pop_front();
                    if (m_tdata !== want.out_pixel)
                    begin
                        $error("out_pixel expected %h actual %h", want.out_pixel, m_tdata);
                        fail_cnt++;
                    end
                    if (m_tuser[0] !== want.changed)
                    begin
                        $error("changed expected %0d actual %0d", want.changed, m_tuser[0]);
                        fail_cnt++;
                    end
                    checked_cnt++;
                    if (!want.changed)
                        passthru_cnt++;
                end
            end
            m_tready <= !((idle_mode == IDLE_SEND_LIGHT && roll_idle(87)) ||
                          (idle_mode == IDLE_SEND_HEAVY && roll_idle(32)));
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CH_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_fracs(input logic [CH_W-1:0] fx, input logic [CH_W-1:0] fy);
        write_reg(CFG_FRAC_X, fx);
        write_reg(CFG_FRAC_Y, fy);
        setting_cnt++;
    endtask

    // sender holds off until the block has delivered everything
    task automatic wait_drained();
        do
            @(posedge clk);
        while (quads_to_send.size() > 0 || s_tvalid || predicted_px.size() > 0);
    endtask

    task automatic add_quad(input logic [PIX_W-1:0] tl, input logic [PIX_W-1:0] tr,
                            input logic [PIX_W-1:0] bl, input logic [PIX_W-1:0] br,
                            input logic [PIX_W-1:0] dst);
        sprite_quad_t q;
        q.top_left     = tl;
        q.top_right    = tr;
        q.bottom_left  = bl;
        q.bottom_right = br;
        q.dest_pixel   = dst;
        quads_to_send.push_back(q);
    endtask

    task automatic run_random_phase(input idle_mode_t mode);
        sprite_quad_t q;
        idle_mode = mode;
        set_fracs(8'($urandom_range(255)), 8'($urandom_range(255)));
        if ($urandom_range(2) == 0)
            write_reg($urandom_range(1) ? CFG_SPARE_2 : CFG_SPARE_3, 8'($urandom()));
        for (int i = 0; i < PHASE_ITEMS; i++)
        begin
            q.top_left     = $urandom();
            q.top_right    = $urandom();
            q.bottom_left  = $urandom();
            q.bottom_right = $urandom();
            q.dest_pixel   = $urandom();
            // transparent sprite area, result must be the destination
            if ($urandom_range(7) == 0)
            begin
                q.top_left[31:24]     = '0;
                q.top_right[31:24]    = '0;
                q.bottom_left[31:24]  = '0;
                q.bottom_right[31:24] = '0;
            end
            quads_to_send.push_back(q);
        end
        wait_drained();
    endtask

    initial
    begin
        logic [CH_W-1:0] dir_fx[5];
        logic [CH_W-1:0] dir_fy[5];
        dir_fx = '{8'd0, 8'd255, 8'd254, 8'd0, 8'd255};
        dir_fy = '{8'd0, 8'd255, 8'd254, 8'd255, 8'd0};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed: fraction extremes, saturated and transparent pixels
        idle_mode = IDLE_SEND_LIGHT;
        for (int s = 0; s < 5; s++)
        begin
            set_fracs(dir_fx[s], dir_fy[s]);
            if (s == 0)
            begin
                write_reg(CFG_SPARE_2, 8'hFF);
                write_reg(CFG_SPARE_3, 8'hA5);
            end
            add_quad('0, '0, '0, '0, '0);
            add_quad('1, '1, '1, '1, '0);
            add_quad(32'h00FFFFFF, 32'h00FFFFFF, 32'h00FFFFFF, 32'h00FFFFFF, 32'h12345678);
            add_quad(32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA, 32'h55555555, 32'hFFFFFFFF);
            add_quad(32'hFF000000 | $urandom(), 32'hFF000000 | $urandom(),
                     32'hFF000000 | $urandom(), 32'hFF000000 | $urandom(), $urandom());
            wait_drained();
        end

        for (int p = 0; p < RAND_PHASES; p++)
            run_random_phase(p < 4 ? IDLE_SEND_LIGHT : (p < 7 ? IDLE_SEND_HEAVY : IDLE_NONE));

        repeat (10) @(posedge clk);
        if (predicted_px.size() != 0)
        begin
            $error("%0d results never arrived", predicted_px.size());
            fail_cnt++;
        end
        $display("checked %0d blended pixels under %0d fraction settings", checked_cnt,
                 setting_cnt);
        $display("%0d of them passed the destination through on zero alpha", passthru_cnt);
        if (fail_cnt == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+sv
sv/sabl_pkg.sv
sv/sabl_queue.sv
sv/sabl_front.sv
sv/sabl_back.sv
sv/subpixel_sprite_alpha_blend_top.sv
verif/subpixel_sprite_alpha_blend_top_tb.sv
